// ----- src/crm_pkg.sv -----
// crm_pkg: shared types and constants of the curve range mapper.
// Used by crm_front, crm_fifo, crm_back and curve_range_mapper.
package crm_pkg;

  // Fraction bits of the internal log and exp arithmetic.
  localparam int IP = 30;
  localparam logic [30:0] IONE = 31'h4000_0000;
  // ln(2) in Q30.
  localparam logic [29:0] LN2_Q30 = 30'd744261118;
  // Truncated 21-term series of e at one, minus one, in Q30.
  localparam logic [31:0] EXP_DEN = 32'd1844991059;
  localparam int EXP_TERMS = 20;
  localparam int Q_DEPTH = 2;

  typedef enum logic [2:0] {
    CURVE_LINEAR    = 3'd0,
    CURVE_FRACT     = 3'd1,
    CURVE_SQUARE    = 3'd2,
    CURVE_LOG       = 3'd3,
    CURVE_FRACT_SQ  = 3'd4,
    CURVE_FRACT_LOG = 3'd5,
    CURVE_EXP       = 3'd6
  } curve_e;

  typedef enum logic [1:0] {
    CFG_MODE = 2'd0,
    CFG_LOW  = 2'd1,
    CFG_HIGH = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    curve_e curve;
    logic   use_div;
  } class_t;

  localparam int CLASS_W = $bits(class_t);

endpackage

// ----- src/curve_range_mapper.sv -----
// curve_range_mapper: top level with configuration registers, front, queue and back.
// Depends on crm_pkg, crm_front, crm_fifo and crm_back.
//
// Maps a position t in [0,1] (unsigned, FRAC_BITS fraction bits, values above one
// saturate) through the curve chosen by curve_mode and returns
// out_low + floor((out_high - out_low) * u) in signed Q16.16. The block takes one
// transaction per clock cycle while out_stall_i is low and keeps that rate for any mix
// of curves. An accepted position passes through the 60-stage chain that runs the
// 30 log2 squaring steps and the 20 exp series terms side by side, followed by the
// FRAC_BITS + 1 stage restoring divider and the final range multiply. A two-entry queue
// lets the input side keep taking transactions while a result waits on the output.
// The user must write configuration through cfg_we_i / cfg_idx_i / cfg_data_i only
// while no transaction is in flight; the block itself does not enforce this.
module curve_range_mapper #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [31:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [FRAC_BITS:0]  position_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [31:0]  mapped_value_o
);

  localparam int TW = FRAC_BITS + 1;
  localparam int QW = crm_pkg::CLASS_W + TW;

  logic [2:0]          mode_q;
  logic signed [31:0]  low_q, high_q;

  logic                push, full, q_valid, q_pop;
  crm_pkg::class_t     f_cls;
  logic [TW-1:0]       f_pos;
  logic [QW-1:0]       q_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= crm_pkg::CURVE_LINEAR;
      low_q  <= 32'sd0;
      high_q <= 32'sd65536;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        crm_pkg::CFG_MODE: mode_q <= cfg_data_i[2:0];
        crm_pkg::CFG_LOW:  low_q  <= cfg_data_i;
        crm_pkg::CFG_HIGH: high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  crm_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .in_valid_i   (in_valid_i),
    .position_i   (position_i),
    .curve_mode_i (mode_q),
    .full_i       (full),
    .in_stall_o   (in_stall_o),
    .push_o       (push),
    .cls_o        (f_cls),
    .pos_o        (f_pos)
  );

  crm_fifo #(.WIDTH(QW)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({f_cls, f_pos}),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_data)
  );

  crm_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_cls_i        (crm_pkg::class_t'(q_data[QW-1 -: crm_pkg::CLASS_W])),
    .q_pos_i        (q_data[TW-1:0]),
    .q_pop_o        (q_pop),
    .low_i          (low_q),
    .high_i         (high_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .mapped_value_o (mapped_value_o)
  );

endmodule

// ----- src/crm_front.sv -----
// crm_front: accepts positions, saturates them to one and classifies the curve.
// Depends on crm_pkg.
module crm_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  in_valid_i,
  input  logic [FRAC_BITS:0]    position_i,
  input  logic [2:0]            curve_mode_i,
  input  logic                  full_i,
  output logic                  in_stall_o,
  output logic                  push_o,
  output crm_pkg::class_t       cls_o,
  output logic [FRAC_BITS:0]    pos_o
);

  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;
  assign pos_o      = (position_i > ONE) ? ONE : position_i;

  always_comb begin
    cls_o.curve   = crm_pkg::CURVE_LINEAR;
    cls_o.use_div = 1'b0;
    unique case (curve_mode_i)
      crm_pkg::CURVE_LINEAR: begin
        cls_o.curve = crm_pkg::CURVE_LINEAR;
      end
      crm_pkg::CURVE_FRACT: begin
        cls_o.curve   = crm_pkg::CURVE_FRACT;
        cls_o.use_div = 1'b1;
      end
      crm_pkg::CURVE_SQUARE: begin
        cls_o.curve = crm_pkg::CURVE_SQUARE;
      end
      crm_pkg::CURVE_LOG: begin
        cls_o.curve = crm_pkg::CURVE_LOG;
      end
      crm_pkg::CURVE_FRACT_SQ: begin
        cls_o.curve   = crm_pkg::CURVE_FRACT_SQ;
        cls_o.use_div = 1'b1;
      end
      crm_pkg::CURVE_FRACT_LOG: begin
        cls_o.curve   = crm_pkg::CURVE_FRACT_LOG;
        cls_o.use_div = 1'b1;
      end
      crm_pkg::CURVE_EXP: begin
        cls_o.curve   = crm_pkg::CURVE_EXP;
        cls_o.use_div = 1'b1;
      end
      // The unused mode code falls back to the linear curve.
      default: begin
        cls_o.curve = crm_pkg::CURVE_LINEAR;
      end
    endcase
  end

endmodule

// ----- src/crm_fifo.sv -----
// crm_fifo: short queue between the front and the back of the mapper.
// Depends on crm_pkg for its depth.
module crm_fifo #(
  parameter int WIDTH = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int AW = $clog2(crm_pkg::Q_DEPTH);

  logic [WIDTH-1:0] mem_q [crm_pkg::Q_DEPTH];
  logic [AW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [AW:0]      cnt_q, cnt_d;

  assign full_o  = (cnt_q == (AW+1)'(crm_pkg::Q_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (AW+1)'(crm_pkg::Q_DEPTH))
    else $error("queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from an empty queue");

endmodule

// ----- src/crm_back.sv -----
// crm_back: pipelined evaluation of the curve, shared divider and range scaling.
// Depends on crm_pkg.
module crm_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  crm_pkg::class_t       q_cls_i,
  input  logic [FRAC_BITS:0]    q_pos_i,
  output logic                  q_pop_o,
  input  logic signed [31:0]    low_i,
  input  logic signed [31:0]    high_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic signed [31:0]    mapped_value_o
);

  localparam int TW    = FRAC_BITS + 1;
  localparam int NSTEP = 3 * crm_pkg::EXP_TERMS;
  localparam int DW    = (2 * FRAC_BITS + 2 > 32) ? 2 * FRAC_BITS + 2 : 32;
  localparam int PW    = 33 + TW + 1;
  localparam logic [TW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  typedef struct packed {
    crm_pkg::class_t cls;
    logic [TW-1:0]   t;
    logic [30:0]     x;
    logic [30:0]     y;
    logic [30:0]     prod;
    logic [30:0]     term;
    logic [31:0]     sum;
    logic [30:0]     est;
  } chain_t;

  typedef struct packed {
    crm_pkg::class_t cls;
    logic [TW-1:0]   t;
    logic [30:0]     y;
    logic [31:0]     sum;
    logic [2*TW-1:0] tt;
    logic [60:0]     yl;
  } prep_t;

  typedef struct packed {
    crm_pkg::class_t cls;
    logic [DW-1:0]   r;
    logic [DW-1:0]   den;
    logic [TW-1:0]   q;
    logic            clamp;
    logic [TW-1:0]   ud;
  } dstep_t;

  logic adv;

  chain_t        chain_q [NSTEP+1];
  chain_t        chain_d [NSTEP];
  chain_t        chain_init;
  logic [NSTEP:0] chain_v_q;

  prep_t  p1_q, p1_d;
  logic   p1_v_q;

  dstep_t      div_q [TW+1];
  dstep_t      div_d [TW];
  dstep_t      div_init;
  logic [TW:0] dv_q;

  logic [TW-1:0]          u_q, u_d;
  logic                   u_v_q;
  logic signed [32:0]     span;
  logic signed [PW-1:0]   m_q, m_d;
  logic                   m_v_q;
  logic signed [PW-1:0]   fl;
  logic signed [31:0]     value_q, value_d;
  logic                   out_valid_q;

  // The whole pipeline moves together unless a finished result is held.
  assign adv     = !out_valid_q || !out_stall_i;
  assign q_pop_o = adv && q_valid_i;

  always_comb begin
    logic [30:0] t30;
    t30 = 31'(q_pos_i) << (crm_pkg::IP - FRAC_BITS);
    chain_init.cls  = q_cls_i;
    chain_init.t    = q_pos_i;
    // At one the log is exactly one; the argument is parked at one.
    chain_init.x    = (q_pos_i == ONE) ? crm_pkg::IONE : (crm_pkg::IONE | t30);
    chain_init.y    = (q_pos_i == ONE) ? crm_pkg::IONE : '0;
    chain_init.prod = '0;
    chain_init.term = crm_pkg::IONE;
    chain_init.sum  = {1'b0, crm_pkg::IONE};
    chain_init.est  = '0;
  end

  // Stage j does one log2 squaring step (first IP stages) and one third of
  // an exp series term: multiply by t, reciprocal estimate, then correction.
  for (genvar j = 0; j < NSTEP; j++) begin : g_chain
    localparam int K   = j / 3 + 1;
    localparam int SUB = j % 3;

    logic [30:0] x_n, y_n, prod_n, term_n, est_n;
    logic [31:0] sum_n;

    if (j < crm_pkg::IP) begin : g_log
      logic [61:0] sq;
      logic [31:0] sh;
      assign sq  = 62'(chain_q[j].x) * 62'(chain_q[j].x);
      assign sh  = sq[61:30];
      assign x_n = sh[31] ? sh[31:1] : sh[30:0];
      assign y_n = chain_q[j].y | (sh[31] ? (31'(1) << (crm_pkg::IP - 1 - j)) : 31'(0));
    end else begin : g_nolog
      assign x_n = chain_q[j].x;
      assign y_n = chain_q[j].y;
    end

    if (SUB == 0) begin : g_mul
      logic [30:0] t30;
      logic [61:0] pt;
      assign t30    = 31'(chain_q[j].t) << (crm_pkg::IP - FRAC_BITS);
      assign pt     = 62'(chain_q[j].term) * 62'(t30);
      assign prod_n = pt[60:30];
      assign est_n  = chain_q[j].est;
      assign term_n = chain_q[j].term;
      assign sum_n  = chain_q[j].sum;
    end else if (SUB == 1) begin : g_recip
      if (K == 1) begin : g_unit
        assign est_n = chain_q[j].prod;
      end else begin : g_scaled
        localparam logic [32:0] RECIP = 33'((64'd1 << 32) / K);
        logic [63:0] pe;
        assign pe    = 64'(chain_q[j].prod) * 64'(RECIP);
        assign est_n = pe[62:32];
      end
      assign prod_n = chain_q[j].prod;
      assign term_n = chain_q[j].term;
      assign sum_n  = chain_q[j].sum;
    end else begin : g_fix
      logic [35:0] rem;
      logic [30:0] qk;
      // The estimate is low by at most one.
      assign rem    = 36'(chain_q[j].prod) - 36'(chain_q[j].est) * 36'(K);
      assign qk     = chain_q[j].est + 31'(rem >= 36'(K));
      assign prod_n = chain_q[j].prod;
      assign est_n  = chain_q[j].est;
      assign term_n = qk;
      assign sum_n  = chain_q[j].sum + 32'(qk);
    end

    assign chain_d[j] = '{cls: chain_q[j].cls, t: chain_q[j].t, x: x_n, y: y_n,
                          prod: prod_n, term: term_n, sum: sum_n, est: est_n};
  end

  always_comb begin
    p1_d.cls = chain_q[NSTEP].cls;
    p1_d.t   = chain_q[NSTEP].t;
    p1_d.y   = chain_q[NSTEP].y;
    p1_d.sum = chain_q[NSTEP].sum;
    p1_d.tt  = (2*TW)'(chain_q[NSTEP].t) * (2*TW)'(chain_q[NSTEP].t);
    p1_d.yl  = 61'(chain_q[NSTEP].y) * 61'(crm_pkg::LN2_Q30);
  end

  always_comb begin
    logic [2*TW:0]   sq_rnd;
    logic [31:0]     lg_rnd;
    logic [60:0]     ln_rnd;
    logic [DW-1:0]   s2;
    logic [DW-1:0]   num;
    logic [DW-1:0]   den;
    logic [TW-1:0]   ud;
    sq_rnd = {1'b0, p1_q.tt} + ((2*TW+1)'(1) << (FRAC_BITS - 1));
    lg_rnd = {1'b0, p1_q.y} + (32'(1) << (crm_pkg::IP - FRAC_BITS - 1));
    ln_rnd = p1_q.yl + (61'(1) << (crm_pkg::IP - 1));
    s2     = DW'(1) << (2 * FRAC_BITS);
    num    = DW'(ONE);
    den    = DW'(ONE);
    ud     = p1_q.t;
    unique case (p1_q.cls.curve)
      crm_pkg::CURVE_LINEAR: ud = p1_q.t;
      crm_pkg::CURVE_SQUARE: ud = sq_rnd[FRAC_BITS +: TW];
      crm_pkg::CURVE_LOG:    ud = TW'(lg_rnd >> (crm_pkg::IP - FRAC_BITS));
      crm_pkg::CURVE_FRACT: begin
        num = DW'(ONE) - DW'(p1_q.t);
        den = DW'(ONE) + DW'(p1_q.t);
      end
      crm_pkg::CURVE_FRACT_SQ: begin
        num = s2 - DW'(p1_q.tt);
        den = s2 + DW'(p1_q.tt);
      end
      crm_pkg::CURVE_FRACT_LOG: begin
        num = DW'(crm_pkg::IONE) - DW'(p1_q.y);
        den = DW'(crm_pkg::IONE) + DW'(ln_rnd[60:crm_pkg::IP]);
      end
      crm_pkg::CURVE_EXP: begin
        num = DW'(p1_q.sum) - DW'(crm_pkg::IONE);
        den = DW'(crm_pkg::EXP_DEN);
      end
      default: ud = p1_q.t;
    endcase
    div_init.cls   = p1_q.cls;
    div_init.r     = num;
    div_init.den   = den;
    div_init.q     = '0;
    div_init.clamp = (num >= den);
    div_init.ud    = ud;
  end

  // One restoring division step per stage.
  for (genvar d = 0; d < TW; d++) begin : g_div
    logic [DW:0] r2;
    logic        ge;
    assign r2 = {div_q[d].r, 1'b0};
    assign ge = (r2 >= {1'b0, div_q[d].den});
    assign div_d[d] = '{cls: div_q[d].cls,
                        r: ge ? DW'(r2 - {1'b0, div_q[d].den}) : DW'(r2),
                        den: div_q[d].den,
                        q: {div_q[d].q[TW-2:0], ge},
                        clamp: div_q[d].clamp,
                        ud: div_q[d].ud};
  end

  always_comb begin
    logic [TW:0] qinc;
    qinc = {1'b0, div_q[TW].q} + (TW+1)'(1);
    if (div_q[TW].clamp && div_q[TW].cls.use_div) begin
      u_d = ONE;
    end else if (div_q[TW].cls.use_div) begin
      u_d = qinc[TW:1];
    end else begin
      u_d = div_q[TW].ud;
    end
  end

  assign span    = {high_i[31], high_i} - {low_i[31], low_i};
  assign m_d     = span * $signed({1'b0, u_q});
  // Arithmetic shift gives the floor for either sign of the product.
  assign fl      = m_q >>> FRAC_BITS;
  assign value_d = low_i + fl[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_v_q   <= '0;
      p1_v_q      <= 1'b0;
      dv_q        <= '0;
      u_v_q       <= 1'b0;
      m_v_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      chain_v_q   <= {chain_v_q[NSTEP-1:0], q_valid_i};
      p1_v_q      <= chain_v_q[NSTEP];
      dv_q        <= {dv_q[TW-1:0], p1_v_q};
      u_v_q       <= dv_q[TW];
      m_v_q       <= u_v_q;
      out_valid_q <= m_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      chain_q[0] <= chain_init;
      for (int j = 0; j < NSTEP; j++) begin
        chain_q[j+1] <= chain_d[j];
      end
      p1_q     <= p1_d;
      div_q[0] <= div_init;
      for (int d = 0; d < TW; d++) begin
        div_q[d+1] <= div_d[d];
      end
      u_q     <= u_d;
      m_q     <= m_d;
      value_q <= value_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign mapped_value_o = value_q;

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> ($stable(chain_v_q) && $stable(dv_q)))
    else $error("pipeline moved while the result was held");

  a_curve_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    u_v_q |-> (u_q <= ONE))
    else $error("curve value above one");

  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_q[0] && div_q[0].cls.use_div && !div_q[0].clamp) |->
      (div_q[0].r < div_q[0].den))
    else $error("divider started with remainder not below divisor");

endmodule

// ----- bench/tb_curve_range_mapper.sv -----
`timescale 1ns / 100ps
// tb_curve_range_mapper: self-checking bench for the curve range mapper.
// Depends on crm_pkg and curve_range_mapper; predicts every mapped value and checks it in order.
module tb_curve_range_mapper;

  localparam logic [2:0] CURVE_SPARE = 3'd7;
  localparam int STALL_LIMIT = 4000;
  localparam longint unsigned Q30_ONE = 64'd1 << 30;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [1:0]        cfg_idx_i = 2'd0;
  logic [31:0]       cfg_data_i = 32'd0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [16:0]       position_i = 17'd0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic signed [31:0] mapped_value_o;

  curve_range_mapper dut (.*);

  always #6 clk_i = ~clk_i;

  // Shadow copy of the configuration registers.
  logic [2:0]        mode_shadow = crm_pkg::CURVE_LINEAR;
  logic signed [31:0] low_shadow = 32'sd0;
  logic signed [31:0] high_shadow = 32'sd65536;

  logic [16:0]       position_queue[$];
  logic signed [31:0] mapped_queue[$];
  int                fail_count = 0;
  int                result_count = 0;
  int                idle_gap = 0;
  int                stall_gap = 0;
  int                long_hold = 0;
  bit                long_hold_done = 1'b0;
  bit                quiet = 1'b0;
  int                silent_cycles = 0;

  // Rounded quotient num * 2^bits / den, clamped at one.
  function automatic longint unsigned round_quotient(longint unsigned num,
                                                     longint unsigned den, int bits);
    longint unsigned q, r;
    q = 0;
    r = num;
    if (den == 0 || num >= den) return 64'd1 << bits;
    for (int i = 0; i < bits + 1; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 1;
      end
    end
    return (q + 1) >> 1;
  endfunction

  // log2 of x in [1,2], both in Q30, by repeated squaring.
  function automatic longint unsigned log2_fixed(longint unsigned x);
    longint unsigned acc;
    acc = 0;
    if (x >= 2 * Q30_ONE) return Q30_ONE;
    for (int i = 1; i <= 30; i++) begin
      x = (x * x) >> 30;
      if (x >= 2 * Q30_ONE) begin
        x = x >> 1;
        acc = acc | (64'd1 << (30 - i));
      end
    end
    return acc;
  endfunction

  // Truncated Taylor series of e^t in Q30.
  function automatic longint unsigned exp_fixed(longint unsigned t);
    longint unsigned term, sum;
    term = Q30_ONE;
    sum = Q30_ONE;
    for (int k = 1; k <= 20; k++) begin
      term = ((term * t) >> 30) / k;
      sum = sum + term;
    end
    return sum;
  endfunction

  function automatic logic signed [31:0] map_position(logic [16:0] pos);
    longint unsigned t, t30, u, y, sq, full;
    longint span, prod;
    t = (pos > 17'd65536) ? 64'd65536 : 64'(pos);
    t30 = t << 14;
    case (mode_shadow)
      crm_pkg::CURVE_FRACT:  u = round_quotient(65536 - t, 65536 + t, 16);
      crm_pkg::CURVE_SQUARE: u = (t * t + 32768) >> 16;
      crm_pkg::CURVE_LOG:    u = (log2_fixed(Q30_ONE + t30) + (64'd1 << 13)) >> 14;
      crm_pkg::CURVE_FRACT_SQ: begin
        sq = t * t;
        full = 64'd1 << 32;
        u = round_quotient(full - sq, full + sq, 16);
      end
      crm_pkg::CURVE_FRACT_LOG: begin
        y = log2_fixed(Q30_ONE + t30);
        u = round_quotient(Q30_ONE - y,
                           Q30_ONE + ((y * 64'(crm_pkg::LN2_Q30) + (Q30_ONE >> 1)) >> 30),
                           16);
      end
      crm_pkg::CURVE_EXP: u = round_quotient(exp_fixed(t30) - Q30_ONE,
                                             exp_fixed(Q30_ONE) - Q30_ONE, 16);
      default: u = t;
    endcase
    span = longint'(high_shadow) - longint'(low_shadow);
    prod = span * longint'(u);
    return 32'(longint'(low_shadow) + (prod >>> 16));
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at result %0d: %s", result_count, what);
    fail_count++;
  endtask

  // Driver: presents queued positions and records the prediction on acceptance.
  logic        drv_valid;
  logic [16:0] drv_position;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      drv_valid = in_valid_i;
      drv_position = position_i;
      if (in_valid_i && !in_stall_o) begin
        mapped_queue.push_back(map_position(position_i));
        void'(position_queue.pop_front());
      end
      if (!in_valid_i || !in_stall_o) begin
        if (idle_gap > 0) begin
          idle_gap--;
          drv_valid = 1'b0;
        end else if (!quiet && $urandom_range(0, 24) == 0) begin
          idle_gap = $urandom_range(0, 18);
          drv_valid = 1'b0;
        end else if (position_queue.size() > 0) begin
          drv_valid = 1'b1;
          drv_position = position_queue[0];
        end else begin
          drv_valid = 1'b0;
        end
      end
      in_valid_i <= drv_valid;
      position_i <= drv_position;
    end
  end

  // Monitor: checks results in order and drives the output stall.
  logic mon_stall;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (mapped_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected mapped_value %0d", mapped_value_o));
        end else if (mapped_value_o !== mapped_queue[0]) begin
          report_mismatch($sformatf("mapped_value %0d, predicted %0d",
                                    mapped_value_o, mapped_queue[0]));
        end
        if (mapped_queue.size() > 0) void'(mapped_queue.pop_front());
        result_count++;
      end
      // One long hold-off lets the pipeline fill and push back on the input.
      if (!long_hold_done && result_count >= 150) begin
        long_hold_done = 1'b1;
        long_hold = 400;
      end
      if (long_hold > 0) begin
        long_hold--;
        mon_stall = 1'b1;
      end else if (stall_gap > 0) begin
        stall_gap--;
        mon_stall = 1'b1;
      end else if (!quiet && $urandom_range(0, 24) == 0) begin
        stall_gap = $urandom_range(0, 18);
        mon_stall = 1'b1;
      end else begin
        mon_stall = 1'b0;
      end
      out_stall_i <= mon_stall;
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
        silent_cycles <= 0;
      else
        silent_cycles <= silent_cycles + 1;
      if (silent_cycles > STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic write_reg(crm_pkg::cfg_idx_e idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    case (idx)
      crm_pkg::CFG_MODE: mode_shadow = data[2:0];
      crm_pkg::CFG_LOW:  low_shadow = data;
      default:           high_shadow = data;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_range(logic [2:0] mode, logic [31:0] lo, logic [31:0] hi);
    write_reg(crm_pkg::CFG_MODE, 32'(mode));
    write_reg(crm_pkg::CFG_LOW, lo);
    write_reg(crm_pkg::CFG_HIGH, hi);
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (position_queue.size() > 0 || in_valid_i || mapped_queue.size() > 0);
  endtask

  function automatic logic [31:0] random_bound();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'd0;
      3: return 32'($urandom_range(0, 131072)) - 32'd65536;
      default: return $urandom;
    endcase
  endfunction

  logic [31:0] dir_low[8] = '{32'd0, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_0000,
                              32'd1234, 32'h8000_0000, 32'd0, 32'h0001_0000};
  logic [31:0] dir_high[8] = '{32'd65536, 32'h7fff_ffff, 32'h8000_0000, 32'h0002_0000,
                               32'd1234, 32'd0, 32'hfff0_0000, 32'd0};
  logic [16:0] dir_pos[3] = '{17'd0, 17'd65536, 17'h1ffff};

  initial begin
    int n;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: every curve including the spare code, edge positions, range extremes.
    for (int m = 0; m < 8; m++) begin
      set_range(3'(m), dir_low[m], dir_high[m]);
      foreach (dir_pos[i]) position_queue.push_back(dir_pos[i]);
      drain();
    end

    for (int ph = 0; ph < 14; ph++) begin
      if (ph == 12) quiet = 1'b1;
      set_range((ph == 1) ? CURVE_SPARE : 3'($urandom_range(0, 7)),
                random_bound(), random_bound());
      n = (ph == 2) ? 250 : 45;
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 4) == 0)
          position_queue.push_back(17'($urandom_range(0, 131071)));
        else
          position_queue.push_back(17'($urandom_range(0, 65536)));
      end
      drain();
    end

    repeat (100) @(posedge clk_i);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/crm_pkg.sv
src/crm_front.sv
src/crm_fifo.sv
src/crm_back.sv
src/curve_range_mapper.sv
bench/tb_curve_range_mapper.sv
